>>> sv/sha1_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 package
// Shared widths, round constants, initial hash words and sequencer states.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 32;
    localparam int NUM_H    = 5;
    localparam int BLOCK_W  = 512;
    localparam int FILL_W   = 6;
    localparam int TOTAL_W  = 61;
    localparam int ROUND_W  = 7;
    localparam int HIDX_W   = 3;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [BYTE_W-1:0] byte_t;

    localparam word_t H_INIT [NUM_H] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam word_t K_0 = 32'h5A827999;
    localparam word_t K_1 = 32'h6ED9EBA1;
    localparam word_t K_2 = 32'h8F1BBCDC;
    localparam word_t K_3 = 32'hCA62C1D6;

    localparam byte_t PAD_MARK = 8'h80;

    localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
    localparam logic [FILL_W-1:0]  LAST_FILL  = 6'd63;
    localparam logic [HIDX_W-1:0]  LAST_WORD  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

endpackage

>>> sv/sha1_msg_if.sv
// ----------------------------------------------------------------------------
// SHA-1 message channel
// Valid/ready channel that carries one message byte and its final flag.
// ----------------------------------------------------------------------------
interface sha1_msg_if;
    logic                          valid;
    logic                          ready;
    logic [sha1_pkg::BYTE_W-1:0]   data_byte;
    logic                          final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

>>> sv/sha1_digest_if.sv
// ----------------------------------------------------------------------------
// SHA-1 digest channel
// Valid/ready channel that carries one digest word and its last flag.
// ----------------------------------------------------------------------------
interface sha1_digest_if;
    logic                          valid;
    logic                          ready;
    logic [sha1_pkg::WORD_W-1:0]   digest_word;
    logic                          digest_last;

    modport source (output valid, output digest_word, output digest_last, input ready);
    modport sink   (input valid, input digest_word, input digest_last, output ready);
endinterface

>>> sv/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Byte-serial SHA-1 hasher with one shared round unit under a sequencer.
// ----------------------------------------------------------------------------
// Feed the message one byte per request on msg, final_byte set on the last
// byte; every message has at least one byte. When a 64-byte block fills, msg
// drops ready while the single round unit runs the SHA-1 rounds (one round
// per cycle) and the working words are folded into the chain value. After
// the final byte the sequencer generates the padding itself, one byte per
// cycle outside the compressions (0x80, zero fill, 64-bit big-endian bit
// length), compressing one or two more blocks, then presents the five digest
// words on digest, H0 first, digest_last on the fifth. The block accepts no
// new byte until the fifth word is taken; the hash state then returns to the
// initial constants for the next message. The bit length wraps modulo 2^64.
// ----------------------------------------------------------------------------
module sha1_message_digest (
    input  logic                  clk,
    input  logic                  rst_n,
    sha1_msg_if.sink              msg,
    sha1_digest_if.source         digest
);

    // Control state
    sha1_pkg::state_t                    state_reg, state_next;
    logic [sha1_pkg::FILL_W-1:0]         fill_reg, fill_next;
    logic [sha1_pkg::TOTAL_W-1:0]        total_reg, total_next;
    logic [sha1_pkg::ROUND_W-1:0]        rnd_reg, rnd_next;
    logic [sha1_pkg::HIDX_W-1:0]         word_reg, word_next;
    logic                                in_pad_reg, in_pad_next;
    logic                                pad_first_reg, pad_first_next;
    logic                                len_ok_reg, len_ok_next;
    logic                                final_blk_reg, final_blk_next;
    sha1_pkg::word_t                     chain_reg [sha1_pkg::NUM_H];
    sha1_pkg::word_t                     chain_next [sha1_pkg::NUM_H];

    // Datapath state
    logic [sha1_pkg::BLOCK_W-1:0]        block_reg, block_next;
    sha1_pkg::word_t                     a_reg, b_reg, c_reg, d_reg, e_reg;
    sha1_pkg::word_t                     a_next, b_next, c_next, d_next, e_next;

    // Byte shift and round unit signals
    logic                                shift_en;
    sha1_pkg::byte_t                     shift_byte;
    logic                                load_work;
    logic [63:0]                         len_bits;
    sha1_pkg::byte_t                     len_byte;
    sha1_pkg::word_t                     w0, w2, w8, w13, w_new;
    sha1_pkg::word_t                     f_val, k_val, t_val;
    logic                                msg_fire, dig_fire;

    assign msg_fire = msg.valid && msg.ready;
    assign dig_fire = digest.valid && digest.ready;

    assign msg.ready          = (state_reg == sha1_pkg::ST_IDLE);
    assign digest.valid       = (state_reg == sha1_pkg::ST_EMIT);
    assign digest.digest_word = chain_reg[word_reg];
    assign digest.digest_last = (word_reg == sha1_pkg::LAST_WORD);

    // Bit length, big-endian: byte i of the trailer sits at fill 56 + i.
    assign len_bits = {total_reg, 3'b000};
    assign len_byte = len_bits[{~fill_reg[2:0], 3'b000} +: 8];

    // Schedule taps: the 16-word window slides one word per round.
    assign w0    = block_reg[511:480];
    assign w2    = block_reg[447:416];
    assign w8    = block_reg[255:224];
    assign w13   = block_reg[95:64];
    assign w_new = {w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0],
                    w13[31] ^ w8[31] ^ w2[31] ^ w0[31]};

    // Shared round unit
    always_comb
    begin
        priority if (rnd_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1_pkg::K_0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1_pkg::K_1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1_pkg::K_2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1_pkg::K_3;
        end
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w0;
    end

    // Sequencer: next state and control
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        total_next     = total_reg;
        rnd_next       = rnd_reg;
        word_next      = word_reg;
        in_pad_next    = in_pad_reg;
        pad_first_next = pad_first_reg;
        len_ok_next    = len_ok_reg;
        final_blk_next = final_blk_reg;
        for (int i = 0; i < sha1_pkg::NUM_H; i++)
        begin
            chain_next[i] = chain_reg[i];
        end
        shift_en   = 1'b0;
        shift_byte = msg.data_byte;
        load_work  = 1'b0;

        unique case (state_reg)
            sha1_pkg::ST_IDLE:
            begin
                if (msg_fire)
                begin
                    shift_en   = 1'b1;
                    shift_byte = msg.data_byte;
                    total_next = total_reg + 1'b1;
                    fill_next  = fill_reg + 1'b1;
                    if (msg.final_byte)
                    begin
                        in_pad_next    = 1'b1;
                        pad_first_next = 1'b1;
                    end
                    if (fill_reg == sha1_pkg::LAST_FILL)
                    begin
                        load_work  = 1'b1;
                        state_next = sha1_pkg::ST_ROUND;
                    end
                    else if (msg.final_byte)
                    begin
                        state_next = sha1_pkg::ST_PAD;
                    end
                end
            end

            sha1_pkg::ST_PAD:
            begin
                // Emit 0x80 first, then zeros, then the length once it fits.
                shift_en  = 1'b1;
                fill_next = fill_reg + 1'b1;
                if (pad_first_reg)
                    shift_byte = sha1_pkg::PAD_MARK;
                else if (len_ok_reg && (fill_reg[5:3] == 3'b111))
                    shift_byte = len_byte;
                else
                    shift_byte = '0;
                pad_first_next = 1'b0;
                if (pad_first_reg)
                    len_ok_next = (fill_reg[5:3] != 3'b111);
                if (fill_reg == sha1_pkg::LAST_FILL)
                begin
                    load_work      = 1'b1;
                    final_blk_next = !pad_first_reg && len_ok_reg;
                    state_next     = sha1_pkg::ST_ROUND;
                end
            end

            sha1_pkg::ST_ROUND:
            begin
                if (rnd_reg == sha1_pkg::LAST_ROUND)
                begin
                    rnd_next   = '0;
                    state_next = sha1_pkg::ST_FOLD;
                end
                else
                begin
                    rnd_next = rnd_reg + 1'b1;
                end
            end

            sha1_pkg::ST_FOLD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                chain_next[4] = chain_reg[4] + e_reg;
                len_ok_next   = 1'b1;
                if (final_blk_reg)
                    state_next = sha1_pkg::ST_EMIT;
                else if (in_pad_reg)
                    state_next = sha1_pkg::ST_PAD;
                else
                    state_next = sha1_pkg::ST_IDLE;
            end

            sha1_pkg::ST_EMIT:
            begin
                if (dig_fire)
                begin
                    if (word_reg == sha1_pkg::LAST_WORD)
                    begin
                        // Restart for the next message.
                        word_next      = '0;
                        total_next     = '0;
                        in_pad_next    = 1'b0;
                        final_blk_next = 1'b0;
                        for (int i = 0; i < sha1_pkg::NUM_H; i++)
                        begin
                            chain_next[i] = sha1_pkg::H_INIT[i];
                        end
                        state_next = sha1_pkg::ST_IDLE;
                    end
                    else
                    begin
                        word_next = word_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = sha1_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        block_next = block_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        if (shift_en)
            block_next = {block_reg[503:0], shift_byte};
        else if (state_reg == sha1_pkg::ST_ROUND)
            block_next = {block_reg[479:0], w_new};

        if (load_work)
        begin
            a_next = chain_reg[0];
            b_next = chain_reg[1];
            c_next = chain_reg[2];
            d_next = chain_reg[3];
            e_next = chain_reg[4];
        end
        else if (state_reg == sha1_pkg::ST_ROUND)
        begin
            a_next = t_val;
            b_next = a_reg;
            c_next = {b_reg[1:0], b_reg[31:2]};
            d_next = c_reg;
            e_next = d_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha1_pkg::ST_IDLE;
            fill_reg      <= '0;
            total_reg     <= '0;
            rnd_reg       <= '0;
            word_reg      <= '0;
            in_pad_reg    <= 1'b0;
            pad_first_reg <= 1'b0;
            len_ok_reg    <= 1'b0;
            final_blk_reg <= 1'b0;
            for (int i = 0; i < sha1_pkg::NUM_H; i++)
            begin
                chain_reg[i] <= sha1_pkg::H_INIT[i];
            end
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            rnd_reg       <= rnd_next;
            word_reg      <= word_next;
            in_pad_reg    <= in_pad_next;
            pad_first_reg <= pad_first_next;
            len_ok_reg    <= len_ok_next;
            final_blk_reg <= final_blk_next;
            for (int i = 0; i < sha1_pkg::NUM_H; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
        end
    end

    // Block window and working words
    always_ff @(posedge clk)
    begin
        block_reg <= block_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        e_reg     <= e_next;
    end

endmodule

>>> test/sha1_digest_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 digest checker
// Watches both channels, hashes each accepted byte on its own copy of the
// SHA-1 state, and compares every digest word with the oldest prediction.
// ----------------------------------------------------------------------------
module sha1_digest_check (
    input  logic    clk,
    input  logic    rst_n,
    sha1_msg_if     msg,
    sha1_digest_if  digest,
    output int      fail_count,
    output int      pending,
    output int      words_checked
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        sha1_pkg::word_t word;
        logic            last;
    } digest_entry_t;

    sha1_pkg::word_t              chain_words [sha1_pkg::NUM_H];
    sha1_pkg::byte_t              block_bytes [64];
    logic [sha1_pkg::TOTAL_W-1:0] msg_len;
    digest_entry_t                digest_due [$];

    function automatic sha1_pkg::word_t rotl(sha1_pkg::word_t v, int n);
        return (v << n) | (v >> (sha1_pkg::WORD_W - n));
    endfunction

    function automatic void compress_block();
        sha1_pkg::word_t sched [80];
        sha1_pkg::word_t a, b, c, d, e, f, k, t;
        int              r;
        for (r = 0; r < 16; r++)
        begin
            sched[r] = {block_bytes[4*r], block_bytes[4*r+1],
                        block_bytes[4*r+2], block_bytes[4*r+3]};
        end
        for (r = 16; r < 80; r++)
        begin
            sched[r] = rotl(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
        end
        a = chain_words[0];
        b = chain_words[1];
        c = chain_words[2];
        d = chain_words[3];
        e = chain_words[4];
        for (r = 0; r < 80; r++)
        begin
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = sha1_pkg::K_0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K_1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1_pkg::K_2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K_3;
            end
            t = rotl(a, 5) + f + e + k + sched[r];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain_words[0] += a;
        chain_words[1] += b;
        chain_words[2] += c;
        chain_words[3] += d;
        chain_words[4] += e;
    endfunction

    // Absorb one message byte; on the final byte pad, finish and queue the digest.
    function automatic void hash_byte(sha1_pkg::byte_t data, logic fin);
        int            pos;
        logic [63:0]   bit_len;
        digest_entry_t entry;
        pos = int'(msg_len[sha1_pkg::FILL_W-1:0]);
        block_bytes[pos] = data;
        msg_len = msg_len + 1'b1;
        if (msg_len[sha1_pkg::FILL_W-1:0] == '0)
            compress_block();
        if (fin)
        begin
            pos = int'(msg_len[sha1_pkg::FILL_W-1:0]);
            block_bytes[pos] = sha1_pkg::PAD_MARK;
            pos++;
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    block_bytes[pos] = '0;
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < 56)
            begin
                block_bytes[pos] = '0;
                pos++;
            end
            bit_len = {msg_len, 3'b000};
            for (int i = 0; i < 8; i++)
                block_bytes[56+i] = bit_len[8*(7-i) +: 8];
            compress_block();
            for (int i = 0; i < sha1_pkg::NUM_H; i++)
            begin
                entry.word = chain_words[i];
                entry.last = (i == sha1_pkg::NUM_H - 1);
                digest_due = {digest_due, entry};
            end
            chain_words = sha1_pkg::H_INIT;
            msg_len = '0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        digest_entry_t due;
        if (!rst_n)
        begin
            chain_words = sha1_pkg::H_INIT;
            msg_len = '0;
            digest_due.delete();
            fail_count = 0;
            pending = 0;
            words_checked = 0;
        end
        else
        begin
            if (msg.valid === 1'b1 && msg.ready === 1'b1)
                hash_byte(msg.data_byte, msg.final_byte);
            if (digest.valid === 1'b1 && digest.ready === 1'b1)
            begin
                words_checked++;
                if (digest_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected digest word %08h last %0b",
                                 $realtime, digest.digest_word, digest.digest_last);
                end
                else
                begin
                    due = digest_due.pop_front();
                    if (digest.digest_word !== due.word || digest.digest_last !== due.last)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"%0t: digest mismatch: expected %08h last %0b, ",
                                      "got %08h last %0b"},
                                     $realtime, due.word, due.last,
                                     digest.digest_word, digest.digest_last);
                    end
                end
            end
            pending = digest_due.size();
        end
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message digest testbench
// Streams short directed messages and then random messages of mixed length
// into the hasher, with bursty requests and a patterned digest stall; the
// checker beside the block predicts and compares every digest word.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 400;
    localparam int BYTE_TARGET  = 400;
    localparam int RX_PHASE     = 150;

    // Digest-side stall modes, cycled through in fixed-length phases.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    logic clk;
    logic rst_n;

    sha1_msg_if    msg_ch ();
    sha1_digest_if dig_ch ();

    int fail_count;
    int pending;
    int words_checked;

    sha1_pkg::byte_t payload [$];
    int              burst_left;
    int              msgs_sent;
    int              bytes_sent;
    int              block_edge_msgs;
    int              long_tail_msgs;
    int              rx_tick;
    rx_mode_t        rx_mode;

    sha1_message_digest uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (dig_ch)
    );

    sha1_digest_check digest_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .msg           (msg_ch),
        .digest        (dig_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // End the run if it goes far past the slowest legal finish.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d digest words still pending",
                 CYCLE_LIMIT, pending);
        $display("FAIL sha1_message_digest");
        $finish;
    end

    // Digest receiver: stall on a phase-driven pattern, including a phase
    // that never stalls.
    initial
    begin
        dig_ch.ready = 1'b0;
        rx_tick = 0;
        forever
        begin
            @(negedge clk);
            rx_mode = rx_mode_t'((rx_tick / RX_PHASE) % 4);
            case (rx_mode)
                RX_OPEN:   dig_ch.ready <= 1'b1;
                RX_COIN:   dig_ch.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: dig_ch.ready <= (rx_tick % 5 == 0);
                default:   dig_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
            rx_tick++;
        end
    end

    // Drive one byte request and hold it until the block takes it. Between
    // bursts drop valid for a random gap; some bursts follow with no gap.
    task automatic send_byte(sha1_pkg::byte_t data, logic fin);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                msg_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        msg_ch.valid      <= 1'b1;
        msg_ch.data_byte  <= data;
        msg_ch.final_byte <= fin;
        do
            @(posedge clk);
        while (msg_ch.ready !== 1'b1);
    endtask

    // Send the bytes in payload as one message, final flag on the last byte.
    task automatic send_payload();
        int len;
        len = payload.size();
        for (int i = 0; i < len; i++)
            send_byte(payload[i], i == len - 1);
        msgs_sent++;
        bytes_sent += len;
        if (len % 64 == 0)
            block_edge_msgs++;
        if (len % 64 >= 56)
            long_tail_msgs++;
    endtask

    // Drop valid and wait until every predicted digest word has come out.
    task automatic hold_until_drained();
        @(negedge clk);
        msg_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic fill_random(int len);
        payload.delete();
        for (int i = 0; i < len; i++)
            payload = {payload, sha1_pkg::byte_t'($urandom_range(0, 255))};
    endtask

    initial
    begin
        int fixed_lens [4];
        int rand_bytes;
        int len;
        int pick;

        msg_ch.valid      = 1'b0;
        msg_ch.data_byte  = '0;
        msg_ch.final_byte = 1'b0;
        rst_n             = 1'b0;
        burst_left        = 0;
        msgs_sent         = 0;
        bytes_sent        = 0;
        block_edge_msgs   = 0;
        long_tail_msgs    = 0;
        fixed_lens        = '{55, 56, 63, 64};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: single-byte messages at both byte extremes, the classic
        // three-byte "abc", and a short message of alternating ones and zeros.
        payload = {8'h00};
        send_payload();
        payload = {8'hFF};
        send_payload();
        payload = {8'h61, 8'h62, 8'h63};
        send_payload();
        payload.delete();
        for (int i = 0; i < 16; i++)
            payload = {payload, ((i % 2 == 0) ? 8'hFF : 8'h00)};
        send_payload();
        hold_until_drained();

        // Random content at the padding boundaries first: the longest tail
        // that still fits, tails that force an extra block, and a message
        // that ends exactly on a block boundary.
        rand_bytes = 0;
        foreach (fixed_lens[i])
        begin
            fill_random(fixed_lens[i]);
            send_payload();
            rand_bytes += fixed_lens[i];
        end

        // Mixed lengths: mostly short, some around one block, a few around two.
        while (rand_bytes < BYTE_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                len = $urandom_range(1, 24);
            else if (pick < 9)
                len = $urandom_range(50, 70);
            else
                len = $urandom_range(110, 130);
            fill_random(len);
            send_payload();
            rand_bytes += len;
            if ($urandom_range(0, 5) == 0)
                hold_until_drained();
        end

        // Drain: wait for the last digest, then give any stray word time to show.
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d messages, %0d bytes, %0d digest words checked",
                 msgs_sent, bytes_sent, words_checked);
        $display("%0d messages ended on a block boundary, %0d needed an extra %s",
                 block_edge_msgs, long_tail_msgs, "padding block");
        if (fail_count == 0 && pending == 0)
            $display("PASS sha1_message_digest");
        else
            $display("FAIL sha1_message_digest");
        $finish;
    end

endmodule
